@@ src/tone_keypad_recorder_player_assert.svh @@
// Assertion macros shared by the recorder and player RTL.
// All of them sample on clk and are held off while rst_n is low.
`ifndef TONE_KEYPAD_RECORDER_PLAYER_ASSERT_SVH
`define TONE_KEYPAD_RECORDER_PLAYER_ASSERT_SVH

// A condition that must hold at every clock edge.
`define TKRP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the same cycle as the trigger.
`define TKRP_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define TKRP_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

@@ src/tkrp_pkg.sv @@
package tkrp_pkg;

    // Default sizes of the song store and the keypad.
    localparam int DEF_SLOTS    = 3;
    localparam int DEF_SONG_LEN = 128;
    localparam int DEF_NOTES    = 12;

    // Fixed field widths.
    localparam int KEY_BITS   = 12;
    localparam int CMD_W      = 3;
    localparam int MODE_W     = 3;
    localparam int NOTE_OUT_W = 4;
    localparam int OCT_W      = 4;
    localparam int REM_W      = 8;
    localparam int LIMIT_W    = 8;
    localparam int ENTRY_W    = 8;

    // Menu button codes.
    localparam logic [CMD_W-1:0] CMD_NONE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_A    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_B    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_C    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_D    = 3'd4;

    // Store entry that means no note.
    localparam logic [ENTRY_W-1:0] SILENT_CODE = 8'hFF;

    // Recording limit after reset.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd120;

    // Octave shift saturation bounds.
    localparam logic signed [OCT_W-1:0] OCT_MAX = 4'sd4;
    localparam logic signed [OCT_W-1:0] OCT_MIN = -4'sd4;

    // Display refresh every whole second of ten ticks; x / 10 is (x * 205) >> 11
    // for every x below 1029.
    localparam int SHOW_PERIOD = 10;
    localparam int RECIP_MUL   = 205;
    localparam int RECIP_SHIFT = 11;

endpackage

@@ src/tone_keypad_recorder_player.sv @@
// Channel Handshake        Fields
// input   in_valid/ready   key_mask cmd
// result  out_valid/ready  mode live_note live_octave play_note play_octave remaining show_update
// config  cfg_wr_en        cfg_wr_data (recording limit)
//
// An accepted item is held in the input register, then its result is computed and registered
// in the result register, so one item per cycle is sustained while results are taken. The
// song store is read one tick ahead, so its registered read does not delay the result.
// Reset clears mode, octave, slot lengths and the handshake at once; the store is not
// cleared since replay only reads entries that the last recording of that slot wrote.
// A held result stalls both registers; in_ready drops once both are full and held.
module tone_keypad_recorder_player #(
    parameter int SLOTS    = tkrp_pkg::DEF_SLOTS,
    parameter int SONG_LEN = tkrp_pkg::DEF_SONG_LEN,
    parameter int NOTES    = tkrp_pkg::DEF_NOTES
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic [tkrp_pkg::LIMIT_W-1:0]            cfg_wr_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [tkrp_pkg::KEY_BITS-1:0]           key_mask,
    input  logic [tkrp_pkg::CMD_W-1:0]              cmd,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [tkrp_pkg::MODE_W-1:0]             mode,
    output logic [tkrp_pkg::NOTE_OUT_W-1:0]         live_note,
    output logic signed [tkrp_pkg::OCT_W-1:0]       live_octave,
    output logic [tkrp_pkg::NOTE_OUT_W-1:0]         play_note,
    output logic signed [tkrp_pkg::OCT_W-1:0]       play_octave,
    output logic [tkrp_pkg::REM_W-1:0]              remaining,
    output logic                                    show_update
);

    `include "tone_keypad_recorder_player_assert.svh"

    localparam int DEPTH      = SLOTS * SONG_LEN;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int POS_W      = $clog2(SONG_LEN + 1);
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NOTE_W     = $clog2(NOTES + 1);
    localparam int KEY_EXT_W  = (NOTES > tkrp_pkg::KEY_BITS) ? NOTES : tkrp_pkg::KEY_BITS;
    localparam int PROD_W     = POS_W + 8;

    // Note index reported while playback is silent.
    localparam logic [tkrp_pkg::NOTE_OUT_W-1:0] NOTE_SILENT = tkrp_pkg::NOTE_OUT_W'(NOTES);

    typedef enum logic [tkrp_pkg::MODE_W-1:0] {
        MODE_FREE     = 3'd0,
        MODE_REC_SEL  = 3'd1,
        MODE_PLAY_SEL = 3'd2,
        MODE_RECORD   = 3'd3,
        MODE_REPLAY   = 3'd4
    } mode_t;

    // Input register.
    logic                               in_valid_reg;
    logic [tkrp_pkg::KEY_BITS-1:0]      key_mask_reg;
    logic [tkrp_pkg::CMD_W-1:0]         cmd_reg;

    // Block state.
    mode_t                              mode_reg, mode_next;
    logic signed [tkrp_pkg::OCT_W-1:0]  oct_reg, oct_next;
    logic [SLOT_W-1:0]                  slot_reg, slot_next;
    logic [POS_W-1:0]                   pos_reg, pos_next;
    logic [POS_W-1:0]                   len_reg [SLOTS];
    logic [tkrp_pkg::LIMIT_W-1:0]       limit_reg;

    // Result register.
    logic                               out_valid_reg;
    logic [tkrp_pkg::MODE_W-1:0]        mode_out_reg;
    logic [tkrp_pkg::NOTE_OUT_W-1:0]    live_note_reg;
    logic signed [tkrp_pkg::OCT_W-1:0]  live_oct_reg;
    logic [tkrp_pkg::NOTE_OUT_W-1:0]    play_note_reg, play_note_next;
    logic signed [tkrp_pkg::OCT_W-1:0]  play_oct_reg, play_oct_next;
    logic [tkrp_pkg::REM_W-1:0]         rem_reg;
    logic                               show_reg, show_next;

    // Working signals of one tick.
    logic                               consume;
    logic [KEY_EXT_W-1:0]               key_ext;
    logic [NOTE_W-1:0]                  live;
    logic [POS_W-1:0]                   lim;
    logic [POS_W-1:0]                   rem;
    logic [PROD_W-1:0]                  prod;
    logic [PROD_W-1:0]                  quot;
    logic [SLOT_W-1:0]                  sel_slot;
    logic                               sel_ok;
    logic [SLOT_W-1:0]                  len_idx;
    logic [POS_W-1:0]                   len_cur;
    logic                               len_we;
    logic                               wr_en;
    logic [ADDR_W-1:0]                  wr_addr;
    logic [tkrp_pkg::ENTRY_W-1:0]       wr_data;
    logic [ADDR_W-1:0]                  rd_addr;
    logic [tkrp_pkg::ENTRY_W-1:0]       rd_data;

    // Conditions watched by the assertions.
    logic                               oct_in_range;
    logic                               pos_in_slot;
    logic                               res_not_replay;
    logic                               play_is_silent;

    function automatic logic signed [tkrp_pkg::OCT_W-1:0] shift_octave(
        input logic signed [tkrp_pkg::OCT_W-1:0] oct,
        input logic [tkrp_pkg::CMD_W-1:0]        c
    );
        logic signed [tkrp_pkg::OCT_W-1:0] res;
        res = oct;
        if (c == tkrp_pkg::CMD_C && oct < tkrp_pkg::OCT_MAX)
        begin
            res = oct + 4'sd1;
        end
        else if (c == tkrp_pkg::CMD_D && oct > tkrp_pkg::OCT_MIN)
        begin
            res = oct - 4'sd1;
        end
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(
        input logic [SLOT_W-1:0] s,
        input logic [POS_W-1:0]  p
    );
        return ADDR_W'(int'(s) * SONG_LEN + int'(p));
    endfunction

    // Handshake: an item is processed when the result register can take it.
    assign consume  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || consume;

    // Live note: the highest pressed key below NOTES.
    always_comb
    begin
        key_ext = KEY_EXT_W'(key_mask_reg);
        live    = NOTE_W'(NOTES);
        for (int i = 0; i < NOTES; i++)
        begin
            if (key_ext[i])
            begin
                live = NOTE_W'(i);
            end
        end
    end

    // Effective recording limit, clamped to 1..SONG_LEN.
    always_comb
    begin
        if (limit_reg == '0)
        begin
            lim = POS_W'(1);
        end
        else if (int'(limit_reg) > SONG_LEN)
        begin
            lim = POS_W'(SONG_LEN);
        end
        else
        begin
            lim = POS_W'(limit_reg);
        end
    end

    // Slot picked by B, C or D in the select modes.
    assign sel_slot = SLOT_W'(cmd_reg - tkrp_pkg::CMD_B);
    assign sel_ok   = (cmd_reg == tkrp_pkg::CMD_B || cmd_reg == tkrp_pkg::CMD_C
                       || cmd_reg == tkrp_pkg::CMD_D)
                      && (int'(cmd_reg - tkrp_pkg::CMD_B) < SLOTS);

    // One read port on the slot lengths.
    assign len_idx = (mode_reg == MODE_PLAY_SEL) ? sel_slot : slot_reg;
    assign len_cur = len_reg[len_idx];

    // Next state and result of one tick.
    always_comb
    begin
        mode_next      = mode_reg;
        oct_next       = oct_reg;
        slot_next      = slot_reg;
        pos_next       = pos_reg;
        rem            = '0;
        show_next      = 1'b0;
        play_note_next = NOTE_SILENT;
        play_oct_next  = '0;
        len_we         = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = store_addr(slot_reg, pos_reg);
        wr_data        = tkrp_pkg::SILENT_CODE;
        case (mode_reg)
            MODE_FREE:
            begin
                if (cmd_reg == tkrp_pkg::CMD_A)
                begin
                    mode_next = MODE_REC_SEL;
                end
                else if (cmd_reg == tkrp_pkg::CMD_B)
                begin
                    mode_next = MODE_PLAY_SEL;
                end
                else
                begin
                    oct_next = shift_octave(oct_reg, cmd_reg);
                end
            end
            MODE_REC_SEL, MODE_PLAY_SEL:
            begin
                if (cmd_reg == tkrp_pkg::CMD_A)
                begin
                    mode_next = MODE_FREE;
                end
                else if (sel_ok)
                begin
                    slot_next = sel_slot;
                    pos_next  = '0;
                    if (mode_reg == MODE_REC_SEL)
                    begin
                        mode_next = MODE_RECORD;
                        rem       = lim;
                    end
                    else
                    begin
                        mode_next = MODE_REPLAY;
                        rem       = len_cur;
                    end
                end
            end
            MODE_RECORD:
            begin
                wr_en    = consume;
                if (live < NOTE_W'(NOTES))
                begin
                    wr_data = {oct_reg, 4'(live)};
                end
                pos_next = pos_reg + POS_W'(1);
                oct_next = shift_octave(oct_reg, cmd_reg);
                if (pos_next >= lim || cmd_reg == tkrp_pkg::CMD_A)
                begin
                    len_we    = 1'b1;
                    mode_next = MODE_FREE;
                end
                else
                begin
                    rem       = lim - pos_next;
                    show_next = 1'b1;
                end
            end
            MODE_REPLAY:
            begin
                pos_next = pos_reg + POS_W'(1);
                oct_next = shift_octave(oct_reg, cmd_reg);
                if (pos_next >= len_cur || cmd_reg == tkrp_pkg::CMD_A)
                begin
                    mode_next = MODE_FREE;
                end
                else
                begin
                    rem       = len_cur - pos_next;
                    show_next = 1'b1;
                    if (rd_data != tkrp_pkg::SILENT_CODE)
                    begin
                        play_note_next = rd_data[3:0];
                        play_oct_next  = rd_data[7:4];
                    end
                end
            end
            default:
            begin
                mode_next = MODE_FREE;
            end
        endcase

        // Whole-second check by multiplying with the reciprocal of ten.
        prod = PROD_W'(rem) * PROD_W'(tkrp_pkg::RECIP_MUL);
        quot = prod >> tkrp_pkg::RECIP_SHIFT;
        if (PROD_W'(quot * PROD_W'(tkrp_pkg::SHOW_PERIOD)) != PROD_W'(rem))
        begin
            show_next = 1'b0;
        end
    end

    // Prefetch the store entry for the tick that follows.
    assign rd_addr = consume ? store_addr(slot_next, pos_next) : store_addr(slot_reg, pos_reg);

    tkrp_song_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= tkrp_pkg::LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            key_mask_reg <= key_mask;
            cmd_reg      <= cmd;
        end
    end

    // Mode, octave and position state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_FREE;
            oct_reg  <= '0;
            slot_reg <= '0;
            pos_reg  <= '0;
        end
        else if (consume)
        begin
            mode_reg <= mode_next;
            oct_reg  <= oct_next;
            slot_reg <= slot_next;
            pos_reg  <= pos_next;
        end
    end

    // Slot lengths, written when a recording ends.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else if (consume && len_we)
        begin
            len_reg[slot_reg] <= pos_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (consume)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume)
        begin
            mode_out_reg  <= mode_next;
            live_note_reg <= tkrp_pkg::NOTE_OUT_W'(live);
            live_oct_reg  <= oct_next;
            play_note_reg <= play_note_next;
            play_oct_reg  <= play_oct_next;
            rem_reg       <= tkrp_pkg::REM_W'(rem);
            show_reg      <= show_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign mode        = mode_out_reg;
    assign live_note   = live_note_reg;
    assign live_octave = live_oct_reg;
    assign play_note   = play_note_reg;
    assign play_octave = play_oct_reg;
    assign remaining   = rem_reg;
    assign show_update = show_reg;

    // Conditions checked below.
    assign oct_in_range   = oct_reg <= tkrp_pkg::OCT_MAX && oct_reg >= tkrp_pkg::OCT_MIN;
    assign pos_in_slot    = int'(pos_reg) < SONG_LEN;
    assign res_not_replay = out_valid_reg && mode_out_reg != MODE_REPLAY;
    assign play_is_silent = play_note_reg == NOTE_SILENT && play_oct_reg == '0;

    // The octave shift stays within its saturation bounds.
    `TKRP_ASSERT_ALWAYS(a_oct_range, oct_in_range, "octave shift out of range")
    // A recording never writes beyond the end of its slot.
    `TKRP_ASSERT_SAME(a_rec_pos, mode_reg == MODE_RECORD, pos_in_slot, "position past slot end")
    // Playback is silent in every result that does not continue a replay.
    `TKRP_ASSERT_SAME(a_play_silent, res_not_replay, play_is_silent, "playback outside replay")
    // A display refresh always shows ticks still to go.
    `TKRP_ASSERT_SAME(a_show_rem, out_valid_reg && show_reg, rem_reg != '0, "refresh at zero")
    // A processed item always leaves a result behind.
    `TKRP_ASSERT_NEXT(a_result, consume, out_valid_reg, "processed item produced no result")

endmodule

@@ src/tkrp_song_store.sv @@
module tkrp_song_store #(
    parameter int DEPTH = tkrp_pkg::DEF_SLOTS * tkrp_pkg::DEF_SONG_LEN
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [$clog2(DEPTH)-1:0]            wr_addr,
    input  logic [tkrp_pkg::ENTRY_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0]            rd_addr,
    output logic [tkrp_pkg::ENTRY_W-1:0]        rd_data
);

    logic [tkrp_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [tkrp_pkg::ENTRY_W-1:0] rd_data_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ verif/tone_keypad_recorder_player_test_pkg.sv @@
`timescale 1ns / 1ps

package tone_keypad_recorder_player_test_pkg;

    // Menu modes as they appear on the mode output.
    typedef enum logic [tkrp_pkg::MODE_W-1:0] {
        MODE_FREE     = 3'd0,
        MODE_REC_SEL  = 3'd1,
        MODE_PLAY_SEL = 3'd2,
        MODE_RECORD   = 3'd3,
        MODE_REPLAY   = 3'd4
    } player_mode_t;

    // Button codes that the menu treats like no event.
    localparam logic [tkrp_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [tkrp_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    // Note index that means nothing is sounding.
    localparam logic [tkrp_pkg::NOTE_OUT_W-1:0] NOTE_SILENT = 4'(tkrp_pkg::DEF_NOTES);

    // Everything the block reports for one tick.
    typedef struct packed {
        player_mode_t                          mode;
        logic [tkrp_pkg::NOTE_OUT_W-1:0]       live_note;
        logic signed [tkrp_pkg::OCT_W-1:0]     live_octave;
        logic [tkrp_pkg::NOTE_OUT_W-1:0]       play_note;
        logic signed [tkrp_pkg::OCT_W-1:0]     play_octave;
        logic [tkrp_pkg::REM_W-1:0]            remaining;
        logic                                  show_update;
    } tick_result_t;

endpackage

@@ verif/tone_keypad_recorder_player_checker.sv @@
`timescale 1ns / 1ps

module tone_keypad_recorder_player_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic [tkrp_pkg::LIMIT_W-1:0]            cfg_wr_data,
    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic [tkrp_pkg::KEY_BITS-1:0]           key_mask,
    input  logic [tkrp_pkg::CMD_W-1:0]              cmd,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic [tkrp_pkg::MODE_W-1:0]             mode,
    input  logic [tkrp_pkg::NOTE_OUT_W-1:0]         live_note,
    input  logic signed [tkrp_pkg::OCT_W-1:0]       live_octave,
    input  logic [tkrp_pkg::NOTE_OUT_W-1:0]         play_note,
    input  logic signed [tkrp_pkg::OCT_W-1:0]       play_octave,
    input  logic [tkrp_pkg::REM_W-1:0]              remaining,
    input  logic                                    show_update,
    output int                                      mismatches,
    output int                                      results_owed
);

    import tkrp_pkg::*;
    import tone_keypad_recorder_player_test_pkg::*;

    // Shadow copy of the player state.
    logic [LIMIT_W-1:0]         limit_reg;
    player_mode_t               menu_mode;
    logic signed [OCT_W-1:0]    octave;
    logic [1:0]                 slot;
    logic [7:0]                 position;
    logic [7:0]                 slot_len [DEF_SLOTS];
    logic [ENTRY_W-1:0]         song [DEF_SLOTS*DEF_SONG_LEN];
    logic [ENTRY_W-1:0]         last_entry;

    // Results still to come, oldest first.
    tick_result_t               tick_results_q [$];
    int                         result_index;

    // One line per mismatch, and the count goes up.
    task automatic report_mismatch(input string msg);
        $display("tb: result %0d: %s", result_index, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int seen, input int wanted);
        if (seen != wanted)
        begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, seen, wanted));
        end
    endtask

    // Buttons C and D move the octave shift, saturating at the bounds.
    function automatic logic signed [OCT_W-1:0] stepped_octave(
        input logic signed [OCT_W-1:0] o,
        input logic [CMD_W-1:0]        c
    );
        if (c == CMD_C && o < OCT_MAX)
        begin
            return o + 4'sd1;
        end
        if (c == CMD_D && o > OCT_MIN)
        begin
            return o - 4'sd1;
        end
        return o;
    endfunction

    // Advances the shadow state by one tick and works out what the block reports.
    task automatic play_tick(
        input  logic [KEY_BITS-1:0] keys,
        input  logic [CMD_W-1:0]    c,
        output tick_result_t        r
    );
        logic [NOTE_OUT_W-1:0]      live;
        logic signed [OCT_W-1:0]    old_octave;
        logic [7:0]                 lim;
        logic [7:0]                 len;
        int                         i;

        // The highest pressed key wins.
        live = NOTE_SILENT;
        for (i = 0; i < DEF_NOTES; i++)
        begin
            if (keys[i])
            begin
                live = 4'(i);
            end
        end
        old_octave = octave;
        if (limit_reg == 0)
        begin
            lim = 8'd1;
        end
        else if (limit_reg > DEF_SONG_LEN)
        begin
            lim = 8'(DEF_SONG_LEN);
        end
        else
        begin
            lim = limit_reg;
        end
        r = '0;

        case (menu_mode)
            MODE_FREE:
            begin
                if (c == CMD_A)
                begin
                    menu_mode = MODE_REC_SEL;
                end
                else if (c == CMD_B)
                begin
                    menu_mode = MODE_PLAY_SEL;
                end
                else
                begin
                    octave = stepped_octave(octave, c);
                end
            end
            MODE_REC_SEL, MODE_PLAY_SEL:
            begin
                if (c == CMD_A)
                begin
                    menu_mode = MODE_FREE;
                end
                else if (c >= CMD_B && c <= CMD_D)
                begin
                    slot = 2'(c - CMD_B);
                    position = '0;
                    if (menu_mode == MODE_REC_SEL)
                    begin
                        menu_mode = MODE_RECORD;
                        r.remaining = lim;
                    end
                    else
                    begin
                        menu_mode = MODE_REPLAY;
                        r.remaining = slot_len[slot];
                    end
                end
            end
            MODE_RECORD:
            begin
                // Each tick stores the live note with the octave in force at its start.
                if (position < DEF_SONG_LEN)
                begin
                    song[slot*DEF_SONG_LEN + position] =
                        (live >= DEF_NOTES) ? SILENT_CODE : {old_octave, live};
                end
                position++;
                octave = stepped_octave(octave, c);
                if (position >= lim || c == CMD_A)
                begin
                    slot_len[slot] = position;
                    menu_mode = MODE_FREE;
                end
                else
                begin
                    r.remaining = lim - position;
                    r.show_update = (r.remaining % SHOW_PERIOD == 0);
                end
            end
            MODE_REPLAY:
            begin
                len = slot_len[slot];
                last_entry = (position < DEF_SONG_LEN) ?
                    song[slot*DEF_SONG_LEN + position] : SILENT_CODE;
                position++;
                octave = stepped_octave(octave, c);
                // The ending tick already sounds silent.
                if (position >= len || c == CMD_A)
                begin
                    menu_mode = MODE_FREE;
                    last_entry = SILENT_CODE;
                end
                else
                begin
                    r.remaining = len - position;
                    r.show_update = (r.remaining % SHOW_PERIOD == 0);
                end
            end
            default:
            begin
                menu_mode = MODE_FREE;
            end
        endcase

        r.mode = menu_mode;
        r.live_note = live;
        r.live_octave = octave;
        if (last_entry == SILENT_CODE)
        begin
            r.play_note = NOTE_SILENT;
            r.play_octave = '0;
        end
        else
        begin
            {r.play_octave, r.play_note} = last_entry;
        end
    endtask

    // Compare results, follow register writes and predict accepted items.
    always @(posedge clk or negedge rst_n)
    begin
        tick_result_t want;
        int           k;

        if (!rst_n)
        begin
            limit_reg = LIMIT_RESET;
            menu_mode = MODE_FREE;
            octave = '0;
            slot = '0;
            position = '0;
            for (k = 0; k < DEF_SLOTS; k++)
            begin
                slot_len[k] = '0;
            end
            for (k = 0; k < DEF_SLOTS*DEF_SONG_LEN; k++)
            begin
                song[k] = SILENT_CODE;
            end
            last_entry = SILENT_CODE;
            tick_results_q.delete();
            result_index = 0;
            mismatches = 0;
            results_owed <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (tick_results_q.size() == 0)
                begin
                    report_mismatch("result arrived with no item waiting for it");
                end
                else
                begin
                    want = tick_results_q.pop_front();
                    check_field("mode", mode, want.mode);
                    check_field("live_note", live_note, want.live_note);
                    check_field("live_octave", live_octave, $signed(want.live_octave));
                    check_field("play_note", play_note, want.play_note);
                    check_field("play_octave", play_octave, $signed(want.play_octave));
                    check_field("remaining", remaining, want.remaining);
                    check_field("show_update", show_update, want.show_update);
                end
                result_index++;
            end
            if (cfg_wr_en)
            begin
                limit_reg = cfg_wr_data;
            end
            if (in_valid && in_ready)
            begin
                play_tick(key_mask, cmd, want);
                tick_results_q.push_back(want);
            end
            results_owed <= tick_results_q.size();
        end
    end

endmodule

@@ verif/tone_keypad_recorder_player_test.sv @@
`timescale 1ns / 1ps

module tone_keypad_recorder_player_test;

    import tkrp_pkg::*;
    import tone_keypad_recorder_player_test_pkg::*;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0]         cfg_wr_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [KEY_BITS-1:0]        key_mask = '0;
    logic [CMD_W-1:0]           cmd = CMD_NONE;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [MODE_W-1:0]          mode;
    logic [NOTE_OUT_W-1:0]      live_note;
    logic signed [OCT_W-1:0]    live_octave;
    logic [NOTE_OUT_W-1:0]      play_note;
    logic signed [OCT_W-1:0]    play_octave;
    logic [REM_W-1:0]           remaining;
    logic                       show_update;
    int                         mismatches;
    int                         results_owed;

    // Coarse menu tracker so that the random part mostly makes sense to the block.
    player_mode_t               trk_mode = MODE_FREE;
    int                         trk_pos = 0;
    int                         trk_slot = 0;
    int                         trk_len [DEF_SLOTS] = '{default: 0};
    int                         trk_limit = LIMIT_RESET;

    // Shape of the current session.
    int                         end_odds = 0;
    int                         oct_bias = 0;
    bit                         send_steady = 1'b0;

    always #2 clk = ~clk;

    tone_keypad_recorder_player i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .key_mask    (key_mask),
        .cmd         (cmd),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mode        (mode),
        .live_note   (live_note),
        .live_octave (live_octave),
        .play_note   (play_note),
        .play_octave (play_octave),
        .remaining   (remaining),
        .show_update (show_update)
    );

    tone_keypad_recorder_player_checker i_checker (.*);

    // Idle stretch: mostly short, now and then long.
    function automatic int idle_span();
        int r;

        r = $urandom_range(99);
        if (r < 75)
        begin
            return $urandom_range(3, 1);
        end
        if (r < 95)
        begin
            return $urandom_range(8, 4);
        end
        return $urandom_range(40, 15);
    endfunction

    // Button event for a tick that should not leave the current mode.
    function automatic logic [CMD_W-1:0] quiet_or_octave();
        int r;
        int up;
        int down;

        r = $urandom_range(99);
        up = (oct_bias == 1) ? 40 : (oct_bias == 2) ? 10 : 15;
        down = (oct_bias == 2) ? 40 : (oct_bias == 1) ? 10 : 15;
        if (r < up)
        begin
            return CMD_C;
        end
        if (r < up + down)
        begin
            return CMD_D;
        end
        if (r < up + down + 6)
        begin
            return 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
        end
        return CMD_NONE;
    endfunction

    // Offer one tick item, wait for it to be taken, then follow the menu.
    task automatic send_tick(input logic [KEY_BITS-1:0] keys, input logic [CMD_W-1:0] c);
        int gap;

        gap = (!send_steady && $urandom_range(99) < 25) ? idle_span() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        key_mask <= keys;
        cmd <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);

        case (trk_mode)
            MODE_FREE:
            begin
                if (c == CMD_A)
                begin
                    trk_mode = MODE_REC_SEL;
                end
                else if (c == CMD_B)
                begin
                    trk_mode = MODE_PLAY_SEL;
                end
            end
            MODE_REC_SEL, MODE_PLAY_SEL:
            begin
                if (c == CMD_A)
                begin
                    trk_mode = MODE_FREE;
                end
                else if (c >= CMD_B && c <= CMD_D)
                begin
                    trk_slot = c - CMD_B;
                    trk_pos = 0;
                    if (trk_mode == MODE_REC_SEL)
                    begin
                        trk_mode = MODE_RECORD;
                    end
                    else
                    begin
                        trk_mode = MODE_REPLAY;
                    end
                end
            end
            MODE_RECORD:
            begin
                trk_pos++;
                if (trk_pos >= trk_limit || c == CMD_A)
                begin
                    trk_len[trk_slot] = trk_pos;
                    trk_mode = MODE_FREE;
                end
            end
            MODE_REPLAY:
            begin
                trk_pos++;
                if (trk_pos >= trk_len[trk_slot] || c == CMD_A)
                begin
                    trk_mode = MODE_FREE;
                end
            end
            default:
            begin
                trk_mode = MODE_FREE;
            end
        endcase
    endtask

    // Drain the block, let it settle, then write the recording limit.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (value == 0)
        begin
            trk_limit = 1;
        end
        else if (value > DEF_SONG_LEN)
        begin
            trk_limit = DEF_SONG_LEN;
        end
        else
        begin
            trk_limit = value;
        end
    endtask

    // Item side: a short directed walk through the menu, then random sessions.
    initial
    begin : stimulus
        logic [LIMIT_W-1:0]     limit_plan [10];
        logic [KEY_BITS-1:0]    keys;
        logic [CMD_W-1:0]       c;
        int                     r;
        int                     wait_cycles;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // A tiny limit lets one recording run into its end.
        write_limit(8'd3);

        // Free play: silence, all keys, lowest and highest key, octave up to saturation.
        send_tick(12'h000, CMD_NONE);
        send_tick(12'hFFF, CMD_C);
        send_tick(12'h001, CMD_C);
        send_tick(12'h800, CMD_C);
        send_tick(12'h400, CMD_C);
        send_tick(12'h555, CMD_C);
        send_tick(12'h000, CMD_SPARE_HI);
        send_tick(12'h002, CMD_D);

        // Record into slot 1 until the limit ends it.
        send_tick(12'h000, CMD_A);
        send_tick(12'h000, CMD_SPARE_LO);
        send_tick(12'h000, CMD_C);
        send_tick(12'h010, CMD_NONE);
        send_tick(12'h000, CMD_D);
        send_tick(12'hFFF, CMD_C);

        // Replay slot 1 and stop it early with A.
        send_tick(12'h000, CMD_B);
        send_tick(12'h000, CMD_C);
        send_tick(12'h000, CMD_NONE);
        send_tick(12'h000, CMD_A);

        // Replay of the empty slot 0 lasts one tick.
        send_tick(12'h000, CMD_B);
        send_tick(12'h000, CMD_B);
        send_tick(12'h000, CMD_NONE);

        // Leaving both select menus with A.
        send_tick(12'h000, CMD_A);
        send_tick(12'h000, CMD_A);
        send_tick(12'h000, CMD_B);
        send_tick(12'h000, CMD_A);

        // Random sessions under a range of limits, out-of-range ones included.
        // Phase ends often fall mid-recording, so limit changes hit live sessions too.
        limit_plan = '{8'd1, 8'd0, 8'd128, 8'd255, 8'($urandom_range(40, 2)), 8'd10,
                       8'd30, 8'($urandom_range(127, 41)), 8'd200, LIMIT_RESET};
        foreach (limit_plan[p])
        begin
            write_limit(limit_plan[p]);
            repeat (130)
            begin
                if ($urandom_range(149) == 0)
                begin
                    send_steady = !send_steady;
                end
                if (trk_mode == MODE_REC_SEL || trk_mode == MODE_PLAY_SEL)
                begin
                    case ($urandom_range(2))
                        0: end_odds = 0;
                        1: end_odds = 4;
                        default: end_odds = 30;
                    endcase
                    oct_bias = $urandom_range(2);
                end

                r = $urandom_range(99);
                if (r < 15)
                begin
                    keys = '0;
                end
                else if (r < 30)
                begin
                    keys = 12'(1) << $urandom_range(KEY_BITS - 1);
                end
                else if (r < 35)
                begin
                    keys = '1;
                end
                else if (r < 40)
                begin
                    keys = 12'h800;
                end
                else
                begin
                    keys = 12'($urandom_range(4095));
                end

                r = $urandom_range(99);
                case (trk_mode)
                    MODE_FREE:
                    begin
                        c = (r < 6) ? CMD_A : (r < 12) ? CMD_B : quiet_or_octave();
                    end
                    MODE_REC_SEL, MODE_PLAY_SEL:
                    begin
                        if (r < 8)
                        begin
                            c = CMD_A;
                        end
                        else if (r < 12)
                        begin
                            c = CMD_NONE;
                        end
                        else if (r < 16)
                        begin
                            c = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
                        end
                        else
                        begin
                            c = CMD_B + 3'($urandom_range(2));
                        end
                    end
                    default:
                    begin
                        c = (end_odds != 0 && $urandom_range(end_odds - 1) == 0) ?
                            CMD_A : quiet_or_octave();
                    end
                endcase
                send_tick(keys, c);
            end
        end

        // Let every result come out, then allow for the pipeline.
        in_valid <= 1'b0;
        wait_cycles = 0;
        @(posedge clk);
        while (results_owed != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (8) @(posedge clk);
        if (mismatches == 0 && results_owed == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // Result side: random back-pressure, plus a long hold-off every few hundred
    // results at a moment when an item is on offer, so the block fills up.
    initial
    begin : result_sink
        int taken;
        int next_hold;
        int pause_left;
        bit sink_steady;

        taken = 0;
        next_hold = 300;
        pause_left = 0;
        sink_steady = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                taken++;
            end
            if (pause_left == 0)
            begin
                if (taken >= next_hold && in_valid)
                begin
                    next_hold = taken + 300;
                    pause_left = 100;
                end
                else if (!sink_steady && $urandom_range(99) < 20)
                begin
                    pause_left = idle_span();
                end
            end
            if ($urandom_range(199) == 0)
            begin
                sink_steady = !sink_steady;
            end
            if (pause_left > 0)
            begin
                out_ready <= 1'b0;
                pause_left--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Hard stop in case the handshakes never complete.
    initial
    begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/tkrp_pkg.sv
src/tkrp_song_store.sv
src/tone_keypad_recorder_player.sv
verif/tone_keypad_recorder_player_test_pkg.sv
verif/tone_keypad_recorder_player_checker.sv
verif/tone_keypad_recorder_player_test.sv
